// ===== design/wnag_pkg.sv =====
// Shared constants of the window neighbour address generator.
package wnag_pkg;

	localparam int PIX_W     = 24;
	localparam int TAP_W     = 5;
	localparam int REG_W     = 13;
	localparam int REG_IDX_W = 2;
	localparam int OUT_DATA_W = 32;

	localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_WINDOW_MODE  = 2'd2;

	localparam logic [REG_W-1:0] RESET_IMAGE_WIDTH  = 13'd640;
	localparam logic [REG_W-1:0] RESET_IMAGE_HEIGHT = 13'd480;

	localparam logic WIN_MODE_3X3 = 1'b0;
	localparam logic WIN_MODE_5X5 = 1'b1;

	localparam int TAPS_3X3 = 9;
	localparam int TAPS_5X5 = 25;

	// Quotient bits resolved per divider cycle and the resulting cycle count.
	localparam int DIV_BITS   = 3;
	localparam int DIV_CYCLES = PIX_W / DIV_BITS;
	localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

endpackage

// ===== design/wnag_front.sv =====
// Front part: accepts a pixel index and splits it into row and column.
module wnag_front #(
	parameter int CW = 14
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [wnag_pkg::PIX_W-1:0]  in_index,
	input  logic [CW-1:0]               dim_w,
	input  logic [CW-1:0]               dim_h,
	output logic                        q_valid,
	input  logic                        q_ready,
	output logic [CW-1:0]               q_row,
	output logic [CW-1:0]               q_col
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_PUSH = 2'd2;

	localparam int PW = wnag_pkg::PIX_W;

	logic [1:0]                       state_q;
	logic [wnag_pkg::DIV_CNT_W-1:0]   cnt_q;
	logic [CW-1:0]                    rem_q;
	logic [PW-1:0]                    quo_q;
	logic [CW-1:0]                    rem_n;
	logic [PW-1:0]                    quo_n;
	logic [CW-1:0]                    h_lim;
	logic                             accept;

	assign in_ready = (state_q == ST_IDLE) || ((state_q == ST_PUSH) && q_ready);
	assign accept   = in_valid && in_ready;
	assign q_valid  = (state_q == ST_PUSH);

	// Restoring division, several quotient bits per cycle.
	always_comb begin
		logic [CW:0] t;
		rem_n = rem_q;
		quo_n = quo_q;
		for (int i = 0; i < wnag_pkg::DIV_BITS; i++) begin
			t = {rem_n, quo_n[PW-1]};
			quo_n = {quo_n[PW-2:0], 1'b0};
			if (t >= {1'b0, dim_w}) begin
				t = t - {1'b0, dim_w};
				quo_n[0] = 1'b1;
			end
			rem_n = t[CW-1:0];
		end
	end

	// A row at or beyond height + 2 clamps exactly as height + 2 does.
	assign h_lim = dim_h + CW'(2);
	assign q_row = (32'(quo_q) > 32'(h_lim)) ? h_lim : quo_q[CW-1:0];
	assign q_col = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_DIV;
						cnt_q   <= '0;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == wnag_pkg::DIV_CNT_W'(wnag_pkg::DIV_CYCLES - 1)) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (q_ready) begin
						state_q <= accept ? ST_DIV : ST_IDLE;
						cnt_q   <= '0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rem_q <= '0;
			quo_q <= in_index;
		end else if (state_q == ST_DIV) begin
			rem_q <= rem_n;
			quo_q <= quo_n;
		end
	end

endmodule

// ===== design/wnag_fifo.sv =====
// Short queue between the front and back parts.
module wnag_fifo #(
	parameter int WIDTH = 28,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  logic [WIDTH-1:0] wr_data,
	output logic             rd_valid,
	input  logic             rd_ready,
	output logic [WIDTH-1:0] rd_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [NW-1:0]    count_q;
	logic             wr_en;
	logic             rd_en;

	assign wr_ready = (count_q != NW'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign wr_en    = wr_valid && wr_ready;
	assign rd_en    = rd_valid && rd_ready;
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== design/wnag_back.sv =====
// Back part: walks the window taps, clamps them and forms the addresses.
module wnag_back #(
	parameter int CW = 14
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	output logic                        q_ready,
	input  logic [CW-1:0]               q_row,
	input  logic [CW-1:0]               q_col,
	input  logic [CW-1:0]               dim_w,
	input  logic [CW-1:0]               dim_h,
	input  logic                        mode,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [wnag_pkg::PIX_W-1:0]  out_addr,
	output logic [wnag_pkg::TAP_W-1:0]  out_tap,
	output logic                        out_last
);

	localparam int SW = CW + 1;
	localparam int MW = (2 * CW + 1 > wnag_pkg::PIX_W) ? 2 * CW + 1 : wnag_pkg::PIX_W;
	localparam int TW = wnag_pkg::TAP_W;

	function automatic logic [CW-1:0] clamp_coord(
		input logic [CW-1:0] base,
		input logic [2:0]    step,
		input logic [2:0]    rad,
		input logic [CW-1:0] lim
	);
		logic [SW-1:0] s;
		logic [SW-1:0] top;
		s   = {1'b0, base} + SW'(step);
		top = {1'b0, lim} - SW'(1);
		if (s < SW'(rad)) begin
			s = '0;
		end else begin
			s = s - SW'(rad);
		end
		if (s > top) begin
			s = top;
		end
		return s[CW-1:0];
	endfunction

	logic          busy_q;
	logic [2:0]    dyi_q;
	logic [2:0]    dxi_q;
	logic [TW-1:0] tap_q;
	logic [CW-1:0] row_q;
	logic [CW-1:0] col_q;

	logic          vld_s1;
	logic [CW-1:0] r_s1;
	logic [CW-1:0] c_s1;
	logic [TW-1:0] tap_s1;
	logic          last_s1;

	logic                       vld_s2;
	logic [wnag_pkg::PIX_W-1:0] addr_s2;
	logic [TW-1:0]              tap_s2;
	logic                       last_s2;

	logic          en;
	logic [2:0]    radius;
	logic [2:0]    side_m1;
	logic [TW-1:0] last_tap;
	logic          seq_last;
	logic          load;
	logic [MW-1:0] prod;

	assign radius   = (mode == wnag_pkg::WIN_MODE_5X5) ? 3'd2 : 3'd1;
	assign side_m1  = (mode == wnag_pkg::WIN_MODE_5X5) ? 3'd4 : 3'd2;
	assign last_tap = (mode == wnag_pkg::WIN_MODE_5X5) ? TW'(wnag_pkg::TAPS_5X5 - 1)
	                                                   : TW'(wnag_pkg::TAPS_3X3 - 1);

	// The whole pipeline moves together whenever the output register can take a step.
	assign en       = !vld_s2 || out_ready;
	assign seq_last = busy_q && (tap_q == last_tap);
	assign q_ready  = en && (!busy_q || seq_last);
	assign load     = q_valid && q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			dyi_q  <= '0;
			dxi_q  <= '0;
			tap_q  <= '0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= busy_q;
			vld_s2 <= vld_s1;
			if (load) begin
				busy_q <= 1'b1;
				dyi_q  <= '0;
				dxi_q  <= '0;
				tap_q  <= '0;
			end else if (busy_q) begin
				if (seq_last) begin
					busy_q <= 1'b0;
				end
				tap_q <= tap_q + 1'b1;
				if (dxi_q == side_m1) begin
					dxi_q <= '0;
					dyi_q <= dyi_q + 1'b1;
				end else begin
					dxi_q <= dxi_q + 1'b1;
				end
			end
		end
	end

	assign prod = MW'(r_s1) * MW'(dim_w) + MW'(c_s1);

	always_ff @(posedge clk) begin
		if (load) begin
			row_q <= q_row;
			col_q <= q_col;
		end
		if (en) begin
			r_s1    <= clamp_coord(row_q, dyi_q, radius, dim_h);
			c_s1    <= clamp_coord(col_q, dxi_q, radius, dim_w);
			tap_s1  <= tap_q;
			last_s1 <= seq_last;
			addr_s2 <= prod[wnag_pkg::PIX_W-1:0];
			tap_s2  <= tap_s1;
			last_s2 <= last_s1;
		end
	end

	assign out_valid = vld_s2;
	assign out_addr  = addr_s2;
	assign out_tap   = tap_s2;
	assign out_last  = last_s2;

endmodule

// ===== design/window_neighbour_address_gen_top.sv =====
// Top level of the window neighbour address generator with replicate border.
//
// Channel   Direction  Moves per transfer
// s_axis    in         one centre pixel index
// m_axis    out        one clamped neighbour address, its tap number and a last mark
// cfg       in         one register write (width, height, window mode)
//
// For a 5x5 window the item rate is set by the back part, which sends one address per cycle
// while m_axis_tready is high; for a 3x3 window it is set by the front divider, which
// resolves three quotient bits a cycle and takes the next index as it hands the row and column
// to the queue. An accepted index reaches m_axis through the divider, the queue, the tap
// counter and the clamp and multiply registers.
// Reset is asynchronous and active low; there is no clearing pass, the block is ready at once.
// When m_axis_tready is low the back pipeline holds as a whole, while the front part keeps
// dividing until the two-entry queue is full.
module window_neighbour_address_gen_top #(
	parameter int MAX_DIM = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// Fields from bit 0 up: pixel_index[23:0].
	input  logic [wnag_pkg::PIX_W-1:0]          s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// Fields from bit 0 up: neighbour_address[23:0], tap_number[28:24], zero fill[31:29].
	output logic [wnag_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	// Carries last_tap.
	output logic                                m_axis_tlast,
	input  logic                                cfg_we,
	input  logic [wnag_pkg::REG_IDX_W-1:0]      cfg_index,
	input  logic [wnag_pkg::REG_W-1:0]          cfg_wdata
);

	// Coordinate width: enough for any clamped dimension plus the two-pixel margin that
	// stands in for rows far beyond the image.
	localparam int CW = $clog2(MAX_DIM + 3);

	// Turns a register value into the dimension actually used: zero reads as one, and
	// anything above the largest supported dimension saturates to it.
	function automatic logic [CW-1:0] eff_dim(input logic [wnag_pkg::REG_W-1:0] v);
		logic [31:0] v32;
		v32 = 32'(v);
		if (v32 == 32'd0) begin
			return CW'(1);
		end else if (v32 > 32'(MAX_DIM)) begin
			return CW'(MAX_DIM);
		end
		return CW'(v32);
	endfunction

	// Configuration is held already reduced to the effective dimensions, so the divider
	// and the clamps see a settled value straight from a flip-flop.
	logic [CW-1:0] dim_w_q;
	logic [CW-1:0] dim_h_q;
	logic          mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_w_q <= eff_dim(wnag_pkg::RESET_IMAGE_WIDTH);
			dim_h_q <= eff_dim(wnag_pkg::RESET_IMAGE_HEIGHT);
			mode_q  <= wnag_pkg::WIN_MODE_3X3;
		end else if (cfg_we) begin
			unique case (cfg_index)
				wnag_pkg::REG_IMAGE_WIDTH:  dim_w_q <= eff_dim(cfg_wdata);
				wnag_pkg::REG_IMAGE_HEIGHT: dim_h_q <= eff_dim(cfg_wdata);
				wnag_pkg::REG_WINDOW_MODE:  mode_q  <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	logic          fq_valid;
	logic          fq_ready;
	logic [CW-1:0] fq_row;
	logic [CW-1:0] fq_col;
	logic          bq_valid;
	logic          bq_ready;
	logic [2*CW-1:0] bq_data;

	logic [wnag_pkg::PIX_W-1:0] addr;
	logic [wnag_pkg::TAP_W-1:0] tap;

	// Front part: index split by iterative division.
	wnag_front #(
		.CW (CW)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_index (s_axis_tdata),
		.dim_w    (dim_w_q),
		.dim_h    (dim_h_q),
		.q_valid  (fq_valid),
		.q_ready  (fq_ready),
		.q_row    (fq_row),
		.q_col    (fq_col)
	);

	// The queue decouples the divider from the tap walker.
	wnag_fifo #(
		.WIDTH (2 * CW),
		.DEPTH (2)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fq_valid),
		.wr_ready (fq_ready),
		.wr_data  ({fq_row, fq_col}),
		.rd_valid (bq_valid),
		.rd_ready (bq_ready),
		.rd_data  (bq_data)
	);

	// Back part: one window address per cycle while m_axis_tready is high, through a clamp stage and a multiply stage.
	wnag_back #(
		.CW (CW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (bq_valid),
		.q_ready   (bq_ready),
		.q_row     (bq_data[2*CW-1:CW]),
		.q_col     (bq_data[CW-1:0]),
		.dim_w     (dim_w_q),
		.dim_h     (dim_h_q),
		.mode      (mode_q),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_addr  (addr),
		.out_tap   (tap),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {
		(wnag_pkg::OUT_DATA_W - wnag_pkg::PIX_W - wnag_pkg::TAP_W)'(0), tap, addr
	};

endmodule

// ===== design/wnag_checker.sv =====
// Port-level checks of the window neighbour address generator, bound to the top level.
module wnag_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	input  logic                            s_axis_tready,
	input  logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	input  logic [wnag_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                            m_axis_tlast
);

	logic [wnag_pkg::TAP_W-1:0] tap;

	assign tap = m_axis_tdata[wnag_pkg::PIX_W+wnag_pkg::TAP_W-1:wnag_pkg::PIX_W];

	// A stalled result keeps its value until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("result changed while stalled");

	// The last mark only sits on the final tap of a 3x3 or 5x5 window.
	a_last_tap: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |->
			(tap == wnag_pkg::TAP_W'(wnag_pkg::TAPS_3X3 - 1)) ||
			(tap == wnag_pkg::TAP_W'(wnag_pkg::TAPS_5X5 - 1)))
		else $error("last mark on a tap that does not end a window");

	// The 25th tap always closes its window.
	a_final_marked: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (tap == wnag_pkg::TAP_W'(wnag_pkg::TAPS_5X5 - 1)) |-> m_axis_tlast)
		else $error("final 5x5 tap without last mark");

	// Once the divider takes an index it is busy and cannot take the next one straight away.
	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("index accepted while the divider was busy");

	// No tap number beyond the largest window.
	a_tap_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (tap < wnag_pkg::TAP_W'(wnag_pkg::TAPS_5X5)))
		else $error("tap number out of range");

endmodule

bind window_neighbour_address_gen_top wnag_checker u_wnag_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
